[rtl/rroc_pkg.sv]
package rroc_pkg;

    localparam int BOX_WIDTH       = 12;
    localparam int TEMP_WIDTH      = 10;
    localparam int CFG_DATA_WIDTH  = 12;
    localparam int CFG_ADDR_WIDTH  = 1;
    localparam int LIMIT_WIDTH     = 24;
    localparam int VERDICT_WIDTH   = 2;
    localparam int OUT_TOTAL_WIDTH = 32;
    localparam int QUEUE_DEPTH     = 8;
    localparam int SETTLE_CYCLES   = 3;
    localparam int SQ_WIDTH        = 2 * BOX_WIDTH;
    localparam int SCALED_WIDTH    = 32;
    localparam int RECIP_WIDTH     = 32;
    localparam int PROD_WIDTH      = SCALED_WIDTH + RECIP_WIDTH;
    // floor(x/1000) == (x * ceil(2^41/1000)) >> 41 for every 32-bit x
    localparam int RECIP_SHIFT     = 41;

    localparam logic [BOX_WIDTH-1:0]   BOX_LENGTH_RESET  = 12'd100;
    localparam logic [TEMP_WIDTH-1:0]  TEMPERATURE_RESET = 10'd1000;
    localparam logic [TEMP_WIDTH-1:0]  TEMP_CAP          = 10'd1000;
    localparam logic [TEMP_WIDTH-1:0]  RATIO_SCALE       = 10'd1000;
    localparam logic [RECIP_WIDTH-1:0] RECIP_1000        = 32'd2199023256;

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        REG_BOX_LENGTH  = 1'b0,
        REG_TEMPERATURE = 1'b1
    } t_cfg_reg;

    typedef enum logic [VERDICT_WIDTH-1:0] {
        VERDICT_OK         = 2'd0,
        VERDICT_OUT_OF_BOX = 2'd1,
        VERDICT_TOTAL      = 2'd2,
        VERDICT_RATIO      = 2'd3
    } t_verdict;

    typedef struct packed {
        logic first;
        logic last;
        logic counts;
        logic hit;     // positive-area intersection
        logic oob;     // candidate fails the boundary test
        logic ratio;   // single overlap exceeds temperature ratio
    } t_item_flags;

    localparam int FLAGS_WIDTH = $bits(t_item_flags);

endpackage

[rtl/rroc_queue.sv]
module rroc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_count != CW'(DEPTH))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue pop while empty");

endmodule

[rtl/rroc_front.sv]
module rroc_front #(
    parameter int COORD_WIDTH = 12,
    parameter int IN_DATA_WIDTH = 104
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [rroc_pkg::CFG_ADDR_WIDTH-1:0]    i_cfg_addr,
    input  logic [rroc_pkg::CFG_DATA_WIDTH-1:0]    i_cfg_data,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [IN_DATA_WIDTH-1:0]               i_s_tdata,
    input  logic [1:0]                             i_s_tuser,
    input  logic                                   i_s_tlast,
    input  logic                                   i_pop,
    output logic                                   o_push,
    output rroc_pkg::t_item_flags                  o_push_flags,
    output logic [2*COORD_WIDTH-1:0]               o_push_area,
    output logic [rroc_pkg::LIMIT_WIDTH-1:0]       o_push_limit
);
    import rroc_pkg::*;

    localparam int C      = COORD_WIDTH;
    localparam int EW     = ((C > BOX_WIDTH) ? C : BOX_WIDTH) + 2;
    localparam int AW     = 2 * C;
    localparam int PW     = AW + TEMP_WIDTH;
    localparam int OFF_CY = C + 1;
    localparam int OFF_CW = 2 * C + 2;
    localparam int OFF_CH = 3 * C + 2;
    localparam int OFF_OX = 4 * C + 2;
    localparam int OFF_OY = 5 * C + 2;
    localparam int OFF_OW = 6 * C + 2;
    localparam int OFF_OH = 7 * C + 2;
    localparam int CRW    = $clog2(QUEUE_DEPTH + 1);
    localparam int STW    = $clog2(SETTLE_CYCLES + 1);

    // configuration and area limit pipeline
    logic [BOX_WIDTH-1:0]    r_box_len;
    logic [TEMP_WIDTH-1:0]   r_temp;
    logic [SQ_WIDTH-1:0]     r_len_sq;
    logic [SCALED_WIDTH-1:0] r_scaled;
    logic [PROD_WIDTH-1:0]   r_prod;
    logic [STW-1:0]          r_settle;
    logic [CRW-1:0]          r_credit, n_credit;
    logic [LIMIT_WIDTH-1:0]  limit_now;
    logic [TEMP_WIDTH-1:0]   tcap_now;
    logic                    accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_len <= BOX_LENGTH_RESET;
            r_temp    <= TEMPERATURE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_BOX_LENGTH:  r_box_len <= i_cfg_data[BOX_WIDTH-1:0];
                REG_TEMPERATURE: r_temp    <= i_cfg_data[TEMP_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_len_sq <= SQ_WIDTH'(r_box_len) * SQ_WIDTH'(r_box_len);
        r_scaled <= SCALED_WIDTH'(r_len_sq[SQ_WIDTH-1:2]) * SCALED_WIDTH'(r_temp);
        r_prod   <= PROD_WIDTH'(r_scaled) * PROD_WIDTH'(RECIP_1000);
    end

    // hold off input until the limit pipeline reflects the current registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_settle <= STW'(SETTLE_CYCLES);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    assign limit_now = LIMIT_WIDTH'(r_prod[PROD_WIDTH-1:RECIP_SHIFT]);
    assign tcap_now  = (r_temp > TEMP_CAP) ? TEMP_CAP : r_temp;

    // one credit per free queue slot not yet claimed by an item in flight
    assign o_s_tready = (r_settle == '0) && (r_credit != '0);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_credit = r_credit;
        if (accept && !i_pop) begin
            n_credit = r_credit - 1'b1;
        end else if (i_pop && !accept) begin
            n_credit = r_credit + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= CRW'(QUEUE_DEPTH);
        end else begin
            r_credit <= n_credit;
        end
    end

    // field unpack and geometry
    logic signed [C:0]    cand_x, cand_y;
    logic [C-1:0]         cand_w, cand_h, other_x, other_y, other_w, other_h;
    logic signed [EW-1:0] cx, cy, cx2, cy2, ox, oy, ox2, oy2, len;
    logic signed [EW-1:0] x1, y1, x2, y2, dx, dy;
    t_item_flags          flags_in;

    always_comb begin
        cand_x  = i_s_tdata[C:0];
        cand_y  = i_s_tdata[OFF_CY +: C + 1];
        cand_w  = i_s_tdata[OFF_CW +: C];
        cand_h  = i_s_tdata[OFF_CH +: C];
        other_x = i_s_tdata[OFF_OX +: C];
        other_y = i_s_tdata[OFF_OY +: C];
        other_w = i_s_tdata[OFF_OW +: C];
        other_h = i_s_tdata[OFF_OH +: C];

        cx  = EW'(cand_x);
        cy  = EW'(cand_y);
        cx2 = cx + signed'(EW'(cand_w));
        cy2 = cy + signed'(EW'(cand_h));
        ox  = signed'(EW'(other_x));
        oy  = signed'(EW'(other_y));
        ox2 = ox + signed'(EW'(other_w));
        oy2 = oy + signed'(EW'(other_h));
        len = signed'(EW'(r_box_len));

        x1 = (cx > ox) ? cx : ox;
        y1 = (cy > oy) ? cy : oy;
        x2 = (cx2 < ox2) ? cx2 : ox2;
        y2 = (cy2 < oy2) ? cy2 : oy2;
        dx = x2 - x1;
        dy = y2 - y1;

        flags_in.first  = i_s_tuser[1];
        flags_in.last   = i_s_tlast;
        flags_in.counts = i_s_tuser[0];
        flags_in.hit    = (x1 < x2) && (y1 < y2);
        flags_in.oob    = cand_x[C] || cand_y[C] || (cx2 > len) || (cy2 > len);
        flags_in.ratio  = 1'b0;
    end

    // stage A: intersection sides
    logic                   r_a_valid;
    t_item_flags            r_a_flags;
    logic [C-1:0]           r_a_dx, r_a_dy, r_a_cw, r_a_ch;
    logic [TEMP_WIDTH-1:0]  r_a_tcap;
    logic [LIMIT_WIDTH-1:0] r_a_limit;
    // stage B: areas
    logic                   r_b_valid;
    t_item_flags            r_b_flags;
    logic [AW-1:0]          r_b_area, r_b_cand;
    logic [TEMP_WIDTH-1:0]  r_b_tcap;
    logic [LIMIT_WIDTH-1:0] r_b_limit;
    // stage C: ratio operands
    logic                   r_c_valid;
    t_item_flags            r_c_flags;
    logic [AW-1:0]          r_c_area;
    logic [PW-1:0]          r_c_scaled, r_c_allow;
    logic [LIMIT_WIDTH-1:0] r_c_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_flags  <= flags_in;
        r_a_dx     <= dx[C-1:0];
        r_a_dy     <= dy[C-1:0];
        r_a_cw     <= cand_w;
        r_a_ch     <= cand_h;
        r_a_tcap   <= tcap_now;
        r_a_limit  <= limit_now;

        r_b_flags  <= r_a_flags;
        r_b_area   <= AW'(r_a_dx) * AW'(r_a_dy);
        r_b_cand   <= AW'(r_a_cw) * AW'(r_a_ch);
        r_b_tcap   <= r_a_tcap;
        r_b_limit  <= r_a_limit;

        r_c_flags  <= r_b_flags;
        r_c_area   <= r_b_area;
        r_c_scaled <= PW'(r_b_area) * PW'(RATIO_SCALE);
        r_c_allow  <= PW'(r_b_tcap) * PW'(r_b_cand);
        r_c_limit  <= r_b_limit;
    end

    always_comb begin
        o_push_flags       = r_c_flags;
        o_push_flags.ratio = r_c_scaled > r_c_allow;
    end

    assign o_push       = r_c_valid;
    assign o_push_area  = r_c_area;
    assign o_push_limit = r_c_limit;

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRW'(QUEUE_DEPTH))
        else $error("queue credit above depth");

endmodule

[rtl/rroc_back.sv]
module rroc_back #(
    parameter int COORD_WIDTH = 12,
    parameter int TOTAL_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_empty,
    input  rroc_pkg::t_item_flags               i_flags,
    input  logic [2*COORD_WIDTH-1:0]            i_area,
    input  logic [rroc_pkg::LIMIT_WIDTH-1:0]    i_limit,
    output logic                                o_pop,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [rroc_pkg::VERDICT_WIDTH-1:0]  o_verdict,
    output logic [rroc_pkg::OUT_TOTAL_WIDTH-1:0] o_total
);
    import rroc_pkg::*;

    localparam int AW  = 2 * COORD_WIDTH;
    localparam int SW  = ((TOTAL_WIDTH > AW) ? TOTAL_WIDTH : AW) + 1;
    localparam int MW  = (TOTAL_WIDTH > LIMIT_WIDTH) ? TOTAL_WIDTH : LIMIT_WIDTH;
    localparam int XW  = (TOTAL_WIDTH > OUT_TOTAL_WIDTH) ? TOTAL_WIDTH : OUT_TOTAL_WIDTH;
    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

    logic [TOTAL_WIDTH-1:0] r_total, n_total;
    t_verdict               r_verdict, n_verdict;
    logic [LIMIT_WIDTH-1:0] r_limit, n_limit;
    logic                   r_out_valid;
    t_verdict               r_out_verdict;
    logic [TOTAL_WIDTH-1:0] r_out_total;
    logic [SW-1:0]          sum;
    logic [XW-1:0]          total_ext;

    // a result waiting in the output register only blocks items that would replace it
    assign o_pop = !i_empty && (!i_flags.last || !r_out_valid || i_m_tready);

    always_comb begin
        n_total   = i_flags.first ? '0 : r_total;
        n_limit   = i_flags.first ? i_limit : r_limit;
        n_verdict = r_verdict;
        if (i_flags.first) begin
            n_verdict = i_flags.oob ? VERDICT_OUT_OF_BOX : VERDICT_OK;
        end
        sum = SW'(n_total) + SW'(i_area);
        if (i_flags.counts && i_flags.hit && n_verdict == VERDICT_OK) begin
            n_total = (sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_WIDTH-1:0];
            if (MW'(n_total) > MW'(n_limit)) begin
                n_verdict = VERDICT_TOTAL;
            end else if (i_flags.ratio) begin
                n_verdict = VERDICT_RATIO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_verdict   <= VERDICT_OK;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_total   <= n_total;
                r_verdict <= n_verdict;
                r_limit   <= n_limit;
            end
            if (o_pop && i_flags.last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_flags.last) begin
            r_out_verdict <= n_verdict;
            r_out_total   <= n_total;
        end
    end

    assign total_ext  = XW'(r_out_total);
    assign o_m_tvalid = r_out_valid;
    assign o_verdict  = r_out_verdict;
    assign o_total    = total_ext[OUT_TOTAL_WIDTH-1:0];

    a_oob_zero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_verdict == VERDICT_OUT_OF_BOX |-> r_total == '0)
        else $error("out-of-box check carries a nonzero total");

    a_rejection_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_flags.first && r_verdict != VERDICT_OK |=>
            $stable(r_verdict) && $stable(r_total))
        else $error("rejected check changed without a new first item");

endmodule

[rtl/relaxed_rectangle_overlap_check.sv]
// Channel  Dir  Signals                  Content
// s        in   i_s_tvalid/o_s_tready    tdata: cand_x, cand_y, cand_w, cand_h, other_x,
//                                        other_y, other_w, other_h; tuser: other_counts,
//                                        first; tlast: last
// m        out  o_m_tvalid/i_m_tready    tdata: verdict, overlap total
// cfg      in   i_cfg_we                 i_cfg_addr selects box_length or temperature
//
// Takes one transaction per cycle while o_s_tready is high; o_m_tvalid rises once the last
// item has passed the 3 front stages (the first loaded on the edge that accepts it), the
// queue write and the back update into the output register.
// The back loop (saturating add and limit compare) retires one item per cycle unless the
// queue is empty or a last item waits on the stalled output register. After reset and after
// every register write the input holds off while the area limit multiplier chain refills.
// An 8-entry queue with credits separates the two halves; a stalled output register
// only holds the back when the next item is a last item.
module relaxed_rectangle_overlap_check #(
    parameter int COORD_WIDTH = 12,
    parameter int TOTAL_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rroc_pkg::CFG_ADDR_WIDTH-1:0] i_cfg_addr,
    input  logic [rroc_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // cand_x, cand_y, cand_w, cand_h, other_x, other_y, other_w, other_h, zero pad
    input  logic [((8*COORD_WIDTH+2+7)/8)*8-1:0] i_s_tdata,
    // other_counts, first
    input  logic [1:0]                          i_s_tuser,
    input  logic                                i_s_tlast,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // verdict, overlap total, zero pad
    output logic [39:0]                         o_m_tdata
);
    import rroc_pkg::*;

    localparam int IN_DATA_WIDTH = ((8 * COORD_WIDTH + 2 + 7) / 8) * 8;
    localparam int AW            = 2 * COORD_WIDTH;
    localparam int QW            = FLAGS_WIDTH + AW + LIMIT_WIDTH;
    localparam int PAD_WIDTH     = 40 - VERDICT_WIDTH - OUT_TOTAL_WIDTH;

    logic                         push, pop, empty;
    t_item_flags                  push_flags;
    logic [AW-1:0]                push_area;
    logic [LIMIT_WIDTH-1:0]       push_limit;
    logic [QW-1:0]                head;
    logic [VERDICT_WIDTH-1:0]     verdict;
    logic [OUT_TOTAL_WIDTH-1:0]   total;

    rroc_front #(
        .COORD_WIDTH   (COORD_WIDTH),
        .IN_DATA_WIDTH (IN_DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_s_tlast    (i_s_tlast),
        .i_pop        (pop),
        .o_push       (push),
        .o_push_flags (push_flags),
        .o_push_area  (push_area),
        .o_push_limit (push_limit)
    );

    rroc_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({push_flags, push_area, push_limit}),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_head      (head)
    );

    rroc_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .TOTAL_WIDTH (TOTAL_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_flags    (t_item_flags'(head[QW-1 -: FLAGS_WIDTH])),
        .i_area     (head[LIMIT_WIDTH +: AW]),
        .i_limit    (head[LIMIT_WIDTH-1:0]),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_verdict  (verdict),
        .o_total    (total)
    );

    assign o_m_tdata = {{PAD_WIDTH{1'b0}}, total, verdict};

endmodule
